### hdl/dmwbc_pkg.sv
// Shared types and constants for the direct-mapped write-back cache.
// No dependencies; used by the cache top level and its checker.
package dmwbc_pkg;

    localparam int ADDR_BITS   = 48;
    localparam int OFFSET_BITS = 6;
    localparam int BEAT_BITS   = 3;
    localparam int WORD_BITS   = 64;
    localparam int MODE_BITS   = 2;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam int MODE_READ_BIT  = 0;
    localparam int MODE_WRITE_BIT = 1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

endpackage

### hdl/direct_mapped_writeback_cache.sv
// Direct-mapped write-back cache, top level.
// Holds the line metadata and line word memories; depends on dmwbc_pkg.
//
// Usage:
//   A request beat is a transfer at a rising edge with start high and busy low,
//   carrying op, address, access_mode, beat and data_word. Each accepted beat
//   gives exactly one result: done is high for one cycle and status, read_word,
//   evicted_address and evicted_word are valid in that cycle. The receiver
//   cannot stall; the result must be taken when done is high.
//   The accepting edge registers the beat and reads the metadata and word
//   memories into registers; in the EXEC state the tag is checked, the
//   memories are written and the result is registered. busy stays high in
//   EXEC, so no new beat is taken while one is in flight and a
//   later beat always sees the write of the earlier one.
//   Reset: rst_n low clears the control state. After release, a clearing pass
//   writes invalid metadata into every line, with busy high; beats are taken only once it ends.
//   Beats at or beyond LINE_WORDS give an all-zero result and change nothing.
module direct_mapped_writeback_cache #(
    parameter int LINE_WORDS = 8,
    parameter int INDEX_BITS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [dmwbc_pkg::ADDR_BITS-1:0]     address,
    input  logic [dmwbc_pkg::MODE_BITS-1:0]     access_mode,
    input  logic [dmwbc_pkg::BEAT_BITS-1:0]     beat,
    input  logic [dmwbc_pkg::WORD_BITS-1:0]     data_word,
    output logic                                done,
    output logic                                status,
    output logic [dmwbc_pkg::WORD_BITS-1:0]     read_word,
    output logic [dmwbc_pkg::ADDR_BITS-1:0]     evicted_address,
    output logic [dmwbc_pkg::WORD_BITS-1:0]     evicted_word
);

    localparam int TAG_BITS  = dmwbc_pkg::ADDR_BITS - dmwbc_pkg::OFFSET_BITS - INDEX_BITS;
    localparam int SLOT_BITS = dmwbc_pkg::BEAT_BITS;
    localparam int LINES     = 1 << INDEX_BITS;
    localparam int WORDS     = LINES << SLOT_BITS;
    localparam logic [SLOT_BITS:0] LINE_END  = (SLOT_BITS+1)'(LINE_WORDS);
    localparam logic [SLOT_BITS:0] LAST_BEAT = (SLOT_BITS+1)'(LINE_WORDS - 1);

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
    } line_meta_t;

    line_meta_t                            meta_mem [LINES];
    logic [dmwbc_pkg::WORD_BITS-1:0]       word_mem [WORDS];

    dmwbc_pkg::state_t                     state_reg, state_next;
    logic [INDEX_BITS-1:0]                 clr_cnt_reg, clr_cnt_next;
    logic                                  done_reg, done_next;

    logic                                  op_reg;
    logic [INDEX_BITS-1:0]                 idx_reg;
    logic [TAG_BITS-1:0]                   tag_reg;
    logic [dmwbc_pkg::MODE_BITS-1:0]       mode_reg;
    logic [SLOT_BITS-1:0]                  beat_reg;
    logic [dmwbc_pkg::WORD_BITS-1:0]       data_reg;

    line_meta_t                            meta_rd_reg;
    logic [dmwbc_pkg::WORD_BITS-1:0]       word_rd_reg;

    logic                                  status_reg, status_next;
    logic [dmwbc_pkg::WORD_BITS-1:0]       read_word_reg, read_word_next;
    logic [dmwbc_pkg::ADDR_BITS-1:0]       evict_addr_reg, evict_addr_next;
    logic [dmwbc_pkg::WORD_BITS-1:0]       evict_word_reg, evict_word_next;

    logic                                  accept;
    logic [INDEX_BITS-1:0]                 in_idx;
    logic [SLOT_BITS+INDEX_BITS-1:0]       in_slot;

    logic                                  meta_we;
    logic [INDEX_BITS-1:0]                 meta_waddr;
    line_meta_t                            meta_wdata;
    logic                                  word_we;

    logic                                  beat_ok;
    logic                                  hit;
    logic                                  victim;

    assign busy    = (state_reg != dmwbc_pkg::ST_IDLE);
    assign accept  = start && !busy;
    assign in_idx  = address[dmwbc_pkg::OFFSET_BITS +: INDEX_BITS];
    assign in_slot = {in_idx, beat};

    assign beat_ok = ({1'b0, beat_reg} < LINE_END);
    assign hit     = meta_rd_reg.valid && (meta_rd_reg.tag == tag_reg);
    assign victim  = meta_rd_reg.valid && meta_rd_reg.dirty;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        done_next       = 1'b0;
        meta_we         = 1'b0;
        meta_waddr      = idx_reg;
        meta_wdata      = '0;
        word_we         = 1'b0;
        status_next     = 1'b0;
        read_word_next  = '0;
        evict_addr_next = '0;
        evict_word_next = '0;

        unique case (state_reg)
            dmwbc_pkg::ST_CLEAR:
            begin
                meta_we      = 1'b1;
                meta_waddr   = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = dmwbc_pkg::ST_IDLE;
                end
            end
            dmwbc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = dmwbc_pkg::ST_EXEC;
                end
            end
            dmwbc_pkg::ST_EXEC:
            begin
                state_next = dmwbc_pkg::ST_IDLE;
                done_next  = 1'b1;
                if (beat_ok)
                begin
                    if (op_reg == dmwbc_pkg::OP_ACCESS)
                    begin
                        status_next = hit;
                        if (hit && mode_reg[dmwbc_pkg::MODE_READ_BIT])
                        begin
                            read_word_next = word_rd_reg;
                        end
                        if (hit && mode_reg[dmwbc_pkg::MODE_WRITE_BIT])
                        begin
                            word_we    = 1'b1;
                            meta_we    = 1'b1;
                            meta_wdata = '{valid: 1'b1, dirty: 1'b1, tag: meta_rd_reg.tag};
                        end
                    end
                    else
                    begin
                        status_next = victim;
                        if (victim)
                        begin
                            evict_addr_next = {meta_rd_reg.tag, idx_reg,
                                               dmwbc_pkg::OFFSET_BITS'(0)};
                            evict_word_next = word_rd_reg;
                        end
                        word_we = 1'b1;
                        if ({1'b0, beat_reg} == LAST_BEAT)
                        begin
                            meta_we    = 1'b1;
                            meta_wdata = '{valid: 1'b1, dirty: 1'b0, tag: tag_reg};
                        end
                    end
                end
            end
            default:
            begin
                state_next = dmwbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dmwbc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            idx_reg  <= in_idx;
            tag_reg  <= address[dmwbc_pkg::ADDR_BITS-1 -: TAG_BITS];
            mode_reg <= access_mode;
            beat_reg <= beat;
            data_reg <= data_word;
        end
        if (state_reg == dmwbc_pkg::ST_EXEC)
        begin
            status_reg     <= status_next;
            read_word_reg  <= read_word_next;
            evict_addr_reg <= evict_addr_next;
            evict_word_reg <= evict_word_next;
        end
    end

    // metadata memory: tag with valid and dirty
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (accept)
        begin
            meta_rd_reg <= meta_mem[in_idx];
        end
    end

    // line word memory, eight slots per line
    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[{idx_reg, beat_reg}] <= data_reg;
        end
        if (accept)
        begin
            word_rd_reg <= word_mem[in_slot];
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign read_word       = read_word_reg;
    assign evicted_address = evict_addr_reg;
    assign evicted_word    = evict_word_reg;

endmodule

### hdl/dmwbc_checker.sv
// Port-level checks for the direct-mapped write-back cache.
// Depends on dmwbc_pkg; bound to direct_mapped_writeback_cache below.
module dmwbc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic                                status,
    input  logic [dmwbc_pkg::WORD_BITS-1:0]     read_word,
    input  logic [dmwbc_pkg::ADDR_BITS-1:0]     evicted_address,
    input  logic [dmwbc_pkg::WORD_BITS-1:0]     evicted_word
);

    // every transfer is followed by its result on done
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result without a beat in flight");

    // no hit and no dirty victim: all data fields zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !status) |-> (read_word == '0 && evicted_address == '0
                               && evicted_word == '0))
        else $error("nonzero data on a result with status clear");

endmodule

bind direct_mapped_writeback_cache dmwbc_checker u_dmwbc_checker (.*);
